@@ rtl/indexed_min_heap_core_macros.svh @@
// Assertion macros shared by the heap checker.
`ifndef INDEXED_MIN_HEAP_CORE_MACROS_SVH
`define INDEXED_MIN_HEAP_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define IMH_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define IMH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/imh_pkg.sv @@
// Types, codes and key compare for the indexed min-heap.
`timescale 1ns / 1ps
package imh_pkg;

  localparam int ITEM_W     = 10;
  localparam int ITEM_COUNT = 1 << ITEM_W;
  localparam int KEY_W      = 32;

  localparam logic [KEY_W-1:0]        MAX_LEN  = '1;
  localparam logic signed [KEY_W-1:0] MAX_YEAR = 32'sh7FFF_FFFF;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_POP   = 2'd1,
    OP_DEC   = 2'd2,
    OP_CLEAR = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_REJECT = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef struct packed {
    logic [ITEM_W-1:0]       item;
    logic [KEY_W-1:0]        len;
    logic signed [KEY_W-1:0] year;
  } slot_t;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_CUR_POS,
    ACT_LOAD,
    ACT_MOV_IN,
    ACT_POP_SAVE,
    ACT_POP_TAKE,
    ACT_WR_MOV,
    ACT_WR_LFT,
    ACT_WR_PAR,
    ACT_LFT_LOAD,
    ACT_PICK,
    ACT_CLEAR,
    ACT_INIT
  } act_t;

  typedef enum logic [2:0] {
    RS_CUR,
    RS_ONE,
    RS_COUNT,
    RS_POS,
    RS_PARENT,
    RS_LEFT,
    RS_RIGHT
  } rsel_t;

  typedef struct packed {
    logic    latch;
    act_t    act;
    rsel_t   rsel;
    logic    fin;
    status_t fin_status;
    logic    fin_pop;
  } dp_cmd_t;

  typedef struct packed {
    opcode_t op;
    logic    full;
    logic    empty;
    logic    hit;
    logic    key_ok;
    logic    root;
    logic    par_wins;
    logic    no_left;
    logic    has_right;
    logic    stay;
    logic    init_last;
  } dp_stat_t;

  // True if key a is better than or equal to key b.
  function automatic logic key_not_worse(input logic [KEY_W-1:0] la,
                                         input logic signed [KEY_W-1:0] ya,
                                         input logic [KEY_W-1:0] lb,
                                         input logic signed [KEY_W-1:0] yb);
    if (la != lb) return la < lb;
    return ya >= yb;
  endfunction

endpackage

@@ rtl/imh_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module imh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/imh_datapath.sv @@
// Heap datapath: slot and position memories, moving entry, result registers.
`timescale 1ns / 1ps
module imh_datapath import imh_pkg::*; #(
  parameter int CAPACITY = 1024,
  localparam int SW = $clog2(CAPACITY + 1)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [1:0]              in_opcode,
  input  logic [ITEM_W-1:0]       in_item_id,
  input  logic [KEY_W-1:0]        in_new_len,
  input  logic signed [KEY_W-1:0] in_new_year,
  input  dp_cmd_t                 cmd,
  output dp_stat_t                stat,
  output logic                    out_valid,
  output logic [1:0]              out_status,
  output logic [ITEM_W-1:0]       out_item,
  output logic [KEY_W-1:0]        out_len,
  output logic signed [KEY_W-1:0] out_year
);

  opcode_t                 op_r;
  logic [ITEM_W-1:0]       item_r;
  logic [KEY_W-1:0]        len_r;
  logic signed [KEY_W-1:0] year_r;
  logic [SW-1:0]           count_r, cur_r, idx_r;
  slot_t                   mov_r, lft_r, pop_r;
  logic                    out_valid_r;
  logic [1:0]              out_status_r;
  slot_t                   out_r;
  logic [ITEM_W-1:0]       init_r;

  logic [SW:0]       left, right, count_ext;
  logic [SW-1:0]     slot_raddr, slot_waddr, pos_wdata, pos_rdata;
  logic              slot_we, pos_we;
  slot_t             slot_wdata, slot_rdata;
  logic [ITEM_W-1:0] pos_waddr;

  assign left      = {cur_r, 1'b0};
  assign right     = left + (SW+1)'(1);
  assign count_ext = {1'b0, count_r};

  always_comb begin
    case (cmd.rsel)
      RS_ONE:    slot_raddr = SW'(1);
      RS_COUNT:  slot_raddr = count_r;
      RS_POS:    slot_raddr = pos_rdata;
      RS_PARENT: slot_raddr = cur_r >> 1;
      RS_LEFT:   slot_raddr = left[SW-1:0];
      RS_RIGHT:  slot_raddr = right[SW-1:0];
      default:   slot_raddr = cur_r;
    endcase
  end

  always_comb begin
    slot_we    = 1'b0;
    slot_waddr = cur_r;
    slot_wdata = mov_r;
    pos_we     = 1'b0;
    pos_waddr  = mov_r.item;
    pos_wdata  = cur_r;
    case (cmd.act)
      ACT_LOAD: begin
        slot_we    = 1'b1;
        slot_waddr = count_r + SW'(1);
        slot_wdata = '{item: item_r, len: MAX_LEN, year: MAX_YEAR};
        pos_we     = 1'b1;
        pos_waddr  = item_r;
        pos_wdata  = count_r + SW'(1);
      end
      ACT_WR_MOV: begin
        slot_we = 1'b1;
        pos_we  = 1'b1;
      end
      ACT_WR_LFT: begin
        slot_we    = 1'b1;
        slot_wdata = lft_r;
        pos_we     = 1'b1;
        pos_waddr  = lft_r.item;
      end
      ACT_WR_PAR: begin
        slot_we    = 1'b1;
        slot_wdata = slot_rdata;
        pos_we     = 1'b1;
        pos_waddr  = slot_rdata.item;
      end
      ACT_INIT: begin
        pos_we    = 1'b1;
        pos_waddr = init_r;
        pos_wdata = '0;
      end
      default: ;
    endcase
  end

  imh_ram #(.WIDTH($bits(slot_t)), .DEPTH(CAPACITY + 1)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  // Position map is zeroed only after reset: an entry counts only if its slot holds the item.
  imh_ram #(.WIDTH(SW), .DEPTH(ITEM_COUNT)) u_pos_ram (
    .clk   (clk),
    .we    (pos_we),
    .waddr (pos_waddr),
    .wdata (pos_wdata),
    .raddr (item_r),
    .rdata (pos_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r   <= opcode_t'(in_opcode);
      item_r <= in_item_id;
      len_r  <= in_new_len;
      year_r <= in_new_year;
    end
    case (cmd.act)
      ACT_CUR_POS:  cur_r <= pos_rdata;
      ACT_MOV_IN:   mov_r <= '{item: item_r, len: len_r, year: year_r};
      ACT_POP_SAVE: pop_r <= slot_rdata;
      ACT_POP_TAKE: begin
        mov_r <= slot_rdata;
        cur_r <= SW'(1);
      end
      ACT_WR_LFT:   cur_r <= idx_r;
      ACT_WR_PAR:   cur_r <= cur_r >> 1;
      ACT_LFT_LOAD: begin
        lft_r <= slot_rdata;
        idx_r <= left[SW-1:0];
      end
      ACT_PICK: begin
        if (!key_not_worse(lft_r.len, lft_r.year, slot_rdata.len, slot_rdata.year)) begin
          lft_r <= slot_rdata;
          idx_r <= right[SW-1:0];
        end
      end
      default: ;
    endcase
    if (cmd.fin) begin
      out_status_r <= cmd.fin_status;
      out_r        <= cmd.fin_pop ? pop_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
      init_r      <= '0;
    end else begin
      out_valid_r <= cmd.fin;
      case (cmd.act)
        ACT_LOAD:     count_r <= count_r + SW'(1);
        ACT_POP_TAKE: count_r <= count_r - SW'(1);
        ACT_CLEAR:    count_r <= '0;
        ACT_INIT:     init_r  <= init_r + ITEM_W'(1);
        default: ;
      endcase
    end
  end

  always_comb begin
    stat.op        = op_r;
    stat.full      = count_r == SW'(CAPACITY);
    stat.empty     = count_r == '0;
    stat.hit       = (cur_r != '0) && (cur_r <= count_r) && (slot_rdata.item == item_r);
    stat.key_ok    = key_not_worse(len_r, year_r, slot_rdata.len, slot_rdata.year);
    stat.root      = cur_r == SW'(1);
    stat.par_wins  = key_not_worse(slot_rdata.len, slot_rdata.year, mov_r.len, mov_r.year);
    stat.no_left   = left > count_ext;
    stat.has_right = right <= count_ext;
    stat.stay      = key_not_worse(mov_r.len, mov_r.year, lft_r.len, lft_r.year);
    stat.init_last = init_r == '1;
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_item   = out_r.item;
  assign out_len    = out_r.len;
  assign out_year   = out_r.year;

endmodule

@@ rtl/imh_ctrl.sv @@
// Heap controller: sequences lookups, sift-up and sift-down over the datapath.
`timescale 1ns / 1ps
module imh_ctrl import imh_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  dp_stat_t stat,
  output logic     busy,
  output dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_DISPATCH, S_SLOT_RD, S_CHECK, S_UP, S_UP_CMP,
    S_POP2, S_POP3, S_DOWN, S_DOWN2, S_DOWN3, S_DCMP
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  always_comb begin
    state_nxt      = state_r;
    cmd.latch      = 1'b0;
    cmd.act        = ACT_NONE;
    cmd.rsel       = RS_CUR;
    cmd.fin        = 1'b0;
    cmd.fin_status = ST_OK;
    cmd.fin_pop    = stat.op == OP_POP;
    unique case (state_r)
      S_INIT: begin
        // zero one position entry per cycle
        cmd.act = ACT_INIT;
        if (stat.init_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (stat.op)
          OP_LOAD: begin
            if (stat.full) begin
              cmd.fin        = 1'b1;
              cmd.fin_status = ST_FULL;
              state_nxt      = S_IDLE;
            end else begin
              state_nxt = S_SLOT_RD;
            end
          end
          OP_POP: begin
            if (stat.empty) begin
              cmd.fin        = 1'b1;
              cmd.fin_status = ST_EMPTY;
              cmd.fin_pop    = 1'b0;
              state_nxt      = S_IDLE;
            end else begin
              cmd.rsel  = RS_ONE;
              state_nxt = S_POP2;
            end
          end
          OP_DEC: state_nxt = S_SLOT_RD;
          default: begin
            cmd.act   = ACT_CLEAR;
            cmd.fin   = 1'b1;
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_SLOT_RD: begin
        cmd.act   = ACT_CUR_POS;
        cmd.rsel  = RS_POS;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (stat.op == OP_LOAD) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
          if (stat.hit) cmd.fin_status = ST_REJECT;
          else          cmd.act        = ACT_LOAD;
        end else if (!stat.hit || !stat.key_ok) begin
          cmd.fin        = 1'b1;
          cmd.fin_status = ST_REJECT;
          state_nxt      = S_IDLE;
        end else begin
          cmd.act   = ACT_MOV_IN;
          state_nxt = S_UP;
        end
      end
      S_UP: begin
        if (stat.root) begin
          cmd.act   = ACT_WR_MOV;
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.rsel  = RS_PARENT;
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (stat.par_wins) begin
          cmd.act   = ACT_WR_MOV;
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.act   = ACT_WR_PAR;
          state_nxt = S_UP;
        end
      end
      S_POP2: begin
        cmd.act   = ACT_POP_SAVE;
        cmd.rsel  = RS_COUNT;
        state_nxt = S_POP3;
      end
      S_POP3: begin
        cmd.act   = ACT_POP_TAKE;
        state_nxt = S_DOWN;
      end
      S_DOWN: begin
        if (stat.no_left) begin
          cmd.act   = ACT_WR_MOV;
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.rsel  = RS_LEFT;
          state_nxt = S_DOWN2;
        end
      end
      S_DOWN2: begin
        cmd.act = ACT_LFT_LOAD;
        if (stat.has_right) begin
          cmd.rsel  = RS_RIGHT;
          state_nxt = S_DOWN3;
        end else begin
          state_nxt = S_DCMP;
        end
      end
      S_DOWN3: begin
        cmd.act   = ACT_PICK;
        state_nxt = S_DCMP;
      end
      S_DCMP: begin
        if (stat.stay) begin
          cmd.act   = ACT_WR_MOV;
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.act   = ACT_WR_LFT;
          state_nxt = S_DOWN;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      busy_r  <= 1'b1;
    end else begin
      state_r <= state_nxt;
      busy_r  <= state_nxt != S_IDLE;
    end
  end

  assign busy = busy_r;

endmodule

@@ rtl/indexed_min_heap_core.sv @@
// Indexed binary min-heap core with position map and decrease-key.
// Full load, empty pop and clear finish in S_DISPATCH; load and key reject in S_CHECK, after S_SLOT_RD.
// Pop: S_POP2, S_POP3, then S_DOWN, S_DOWN2, S_DOWN3 (with a right child) and S_DCMP per level.
// Decrease-key: S_SLOT_RD, S_CHECK, then S_UP and S_UP_CMP per level; the strobe is registered.
// One item at a time; start is taken again in the cycle the result strobe shows.
// Reset empties the heap; busy then stays high while the position map clears.
`timescale 1ns / 1ps
module indexed_min_heap_core import imh_pkg::*; #(
  parameter int CAPACITY = 1024
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              in_opcode,
  input  logic [ITEM_W-1:0]       in_item_id,
  input  logic [KEY_W-1:0]        in_new_len,
  input  logic signed [KEY_W-1:0] in_new_year,
  output logic                    out_valid,
  output logic [1:0]              out_status,
  output logic [ITEM_W-1:0]       out_item,
  output logic [KEY_W-1:0]        out_len,
  output logic signed [KEY_W-1:0] out_year
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  imh_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  imh_datapath #(.CAPACITY(CAPACITY)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_opcode   (in_opcode),
    .in_item_id  (in_item_id),
    .in_new_len  (in_new_len),
    .in_new_year (in_new_year),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_status  (out_status),
    .out_item    (out_item),
    .out_len     (out_len),
    .out_year    (out_year)
  );

endmodule

@@ rtl/imh_checker.sv @@
// Port-level checker for the heap core, bound to the top level.
`timescale 1ns / 1ps
`include "indexed_min_heap_core_macros.svh"
module imh_checker import imh_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    start,
  input logic                    busy,
  input logic [1:0]              in_opcode,
  input logic [ITEM_W-1:0]       in_item_id,
  input logic [KEY_W-1:0]        in_new_len,
  input logic signed [KEY_W-1:0] in_new_year,
  input logic                    out_valid,
  input logic [1:0]              out_status,
  input logic [ITEM_W-1:0]       out_item,
  input logic [KEY_W-1:0]        out_len,
  input logic signed [KEY_W-1:0] out_year
);

  `IMH_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
  `IMH_ASSERT_NEXT(a_strobe_single, out_valid, !out_valid, "result strobe held two cycles")
  `IMH_ASSERT_NOW(a_strobe_after_busy, out_valid, $past(busy) && !busy, "result without busy")
  `IMH_ASSERT_NOW(a_non_ok_zero, out_valid && (out_status != ST_OK), (out_item == '0) && (out_len == '0) && (out_year == '0), "non-ok result carries data")

endmodule

bind indexed_min_heap_core imh_checker u_imh_checker (.*);
